>>> rtl/hsv_pkg.sv
package hsv_pkg;

    // One source pixel and one adjusted pixel.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HUE_SHIFT    = 3'd0;
    localparam logic [2:0] CFG_SAT_ADJUST   = 3'd1;
    localparam logic [2:0] CFG_VAL_ADJUST   = 3'd2;
    localparam logic [2:0] CFG_SAT_ADDITIVE = 3'd3;
    localparam logic [2:0] CFG_VAL_ADDITIVE = 3'd4;

    // Pipelined restoring divider: one quotient bit per stage.
    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_QUO_W = 13;

endpackage

>>> rtl/hsv_div.sv
module hsv_div (
    input  logic                               clk,
    input  logic                               adv,
    input  logic [hsv_pkg::DIV_NUM_W-1:0]      num,
    input  logic [hsv_pkg::DIV_DEN_W-1:0]      den,
    output logic [hsv_pkg::DIV_QUO_W-1:0]      quo
);
    import hsv_pkg::*;

    logic [DIV_NUM_W-1:0] rem_reg  [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] quo_reg  [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] rem_next [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] quo_next [DIV_QUO_W];

    // Each stage tries to subtract the divisor shifted to its quotient bit.
    always_comb
    begin
        logic [DIV_NUM_W-1:0] rem_cur;
        logic [DIV_DEN_W-1:0] den_cur;
        logic [DIV_QUO_W-1:0] quo_cur;
        logic [DIV_NUM_W:0]   dsh;
        logic [DIV_NUM_W:0]   trial;
        for (int k = 0; k < DIV_QUO_W; k++)
        begin
            if (k == 0)
            begin
                rem_cur = num;
                den_cur = den;
                quo_cur = '0;
            end
            else
            begin
                rem_cur = rem_reg[k-1];
                den_cur = den_reg[k-1];
                quo_cur = quo_reg[k-1];
            end
            dsh   = {{(DIV_NUM_W+1-DIV_DEN_W){1'b0}}, den_cur} << (DIV_QUO_W-1-k);
            trial = {1'b0, rem_cur} - dsh;
            rem_next[k] = rem_cur;
            quo_next[k] = quo_cur;
            if (!trial[DIV_NUM_W])
            begin
                rem_next[k] = trial[DIV_NUM_W-1:0];
                quo_next[k][DIV_QUO_W-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= (k == 0) ? den : den_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[DIV_QUO_W-1];

endmodule

>>> rtl/hsv_shift_pixel.sv
// Per-pixel HSV adjustment. Each request carries one 8-bit RGB pixel; the
// block converts it to HSV (hue in 1/64 degree, S and V in Q12), adds the
// hue shift with wrap at 360 degrees, offsets or scales S and V as the mode
// bits select, clamps them to [0,1] and converts back to RGB, truncating to
// 8 bits. With all three adjustments zero the pixel passes unchanged. One
// pixel is taken every clock unless the output stalls. The pipeline has one
// input stage, 13 stages of the bit-per-stage divider that forms hue and
// saturation, and seven stages for the adjustment and back conversion. The
// whole pipeline holds while a finished pixel waits under dst_stall. Write
// configuration only while no pixel is in flight.
module hsv_shift_pixel (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  hsv_pkg::pixel_in_t    src_data,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output hsv_pkg::pixel_out_t   dst_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_wdata
);
    import hsv_pkg::*;

    typedef struct packed {
        pixel_in_t          pix;
        logic signed [15:0] off;
        logic               c_zero;
        logic               mx_zero;
        logic [7:0]         mx;
    } side_t;

    // Configuration registers.
    logic signed [15:0] hue_shift_reg;
    logic signed [14:0] sat_adjust_reg;
    logic signed [14:0] val_adjust_reg;
    logic               sat_additive_reg;
    logic               val_additive_reg;

    logic adv;

    // Input stage.
    logic      s0_valid_reg;
    pixel_in_t s0_pix_reg;

    // Divider side band.
    logic  dv_valid_reg [DIV_QUO_W];
    side_t dv_side_reg  [DIV_QUO_W];
    side_t side_next;
    logic [DIV_NUM_W-1:0] num_h;
    logic [DIV_NUM_W-1:0] num_s;
    logic [DIV_DEN_W-1:0] den_h;
    logic [DIV_QUO_W-1:0] quo_h;
    logic [DIV_QUO_W-1:0] quo_s;

    // Post stages.
    logic        p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic        p5_valid_reg, p6_valid_reg, p7_valid_reg;
    pixel_in_t   p1_pix_reg, p2_pix_reg, p3_pix_reg, p4_pix_reg, p5_pix_reg, p6_pix_reg;
    logic [14:0] p1_hue_reg;
    logic [12:0] p1_sat_reg, p1_val_reg;
    logic [14:0] p2_h_reg;
    logic [12:0] p2_s_reg, p2_v_reg;
    logic [2:0]  p3_sector_reg, p4_sector_reg, p5_sector_reg, p6_sector_reg;
    logic [11:0] p3_f_reg;
    logic [12:0] p3_s_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg;
    logic [24:0] p4_p_reg;
    logic [12:0] p4_kp_reg, p5_kp_reg;
    logic [33:0] p5_sfm_reg;
    logic [24:0] p6_xp_reg, p6_xq_reg, p6_xt_reg;
    pixel_out_t  p7_out_reg;

    logic [14:0] p1_hue_next;
    logic [12:0] p1_sat_next, p1_val_next;
    logic [14:0] p2_h_next;
    logic [12:0] p2_s_next, p2_v_next;
    logic [2:0]  p3_sector_next;
    logic [11:0] p3_f_next;
    logic [12:0] p6_sf;
    logic [12:0] p6_kq, p6_kt;
    pixel_out_t  p7_out_next;

    function automatic logic [12:0] adjust(input logic [12:0] x,
                                           input logic signed [14:0] adj,
                                           input logic additive);
        logic signed [15:0] sum;
        logic signed [28:0] prod;
        logic signed [28:0] r;
        sum  = $signed({3'b000, x}) + 16'(adj);
        prod = $signed({16'd0, x}) * 29'(adj);
        if (additive)
            r = 29'(sum);
        else if (prod < 0)
            r = '0;
        else
            r = prod >>> 12;
        if (r < 0)
            return 13'd0;
        else if (r > 29'sd4096)
            return 13'd4096;
        else
            return r[12:0];
    endfunction

    // Scale a Q24 product by 255 and keep the integer part.
    function automatic logic [7:0] chan_of(input logic [24:0] x);
        logic [32:0] w;
        w = {x, 8'd0} - {8'd0, x};
        return w[31:24];
    endfunction

    assign adv       = !(p7_valid_reg && dst_stall);
    assign src_stall = !adv;
    assign dst_valid = p7_valid_reg;
    assign dst_data  = p7_out_reg;

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg    <= '0;
            sat_adjust_reg   <= '0;
            val_adjust_reg   <= '0;
            sat_additive_reg <= 1'b0;
            val_additive_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HUE_SHIFT:    hue_shift_reg    <= cfg_wdata;
                CFG_SAT_ADJUST:   sat_adjust_reg   <= cfg_wdata[14:0];
                CFG_VAL_ADJUST:   val_adjust_reg   <= cfg_wdata[14:0];
                CFG_SAT_ADDITIVE: sat_additive_reg <= cfg_wdata[0];
                CFG_VAL_ADDITIVE: val_additive_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Front end: max, min, chroma and the hue numerator for the divider.
    // Hue = base - 3840 + floor(3840 * (d + C) / C), with d + C >= 0.
    always_comb
    begin
        logic [7:0] r, g, b, mx, mn, c;
        logic [9:0] dc;
        r  = s0_pix_reg.red_in;
        g  = s0_pix_reg.green_in;
        b  = s0_pix_reg.blue_in;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        side_next.pix     = s0_pix_reg;
        side_next.mx      = mx;
        side_next.c_zero  = (c == 8'd0);
        side_next.mx_zero = (mx == 8'd0);
        if (mx == r)
        begin
            dc = {2'b00, g} - {2'b00, b} + {2'b00, c};
            side_next.off = (g < b) ? 16'sd19200 : -16'sd3840;
        end
        else if (mx == g)
        begin
            dc = {2'b00, b} - {2'b00, r} + {2'b00, c};
            side_next.off = 16'sd3840;
        end
        else
        begin
            dc = {2'b00, r} - {2'b00, g} + {2'b00, c};
            side_next.off = 16'sd11520;
        end
        num_h = {dc[8:0], 12'd0} - {4'd0, dc[8:0], 8'd0};
        num_s = {1'b0, c, 12'd0};
        // A gray pixel has no hue; feed a harmless divisor.
        den_h = (c == 8'd0) ? 8'd1 : c;
    end

    hsv_div u_div_hue (
        .clk (clk),
        .adv (adv),
        .num (num_h),
        .den (den_h),
        .quo (quo_h)
    );

    hsv_div u_div_sat (
        .clk (clk),
        .adv (adv),
        .num (num_s),
        .den (side_next.mx),
        .quo (quo_s)
    );

    // Stage 1: finish hue, saturation and value.
    always_comb
    begin
        logic signed [15:0] hsum;
        logic [11:0] y;
        logic [12:0] vq;
        side_t sd;
        sd   = dv_side_reg[DIV_QUO_W-1];
        hsum = sd.off + $signed({3'b000, quo_h});
        p1_hue_next = sd.c_zero ? 15'd0 : hsum[14:0];
        p1_sat_next = sd.mx_zero ? 13'd0 : quo_s;
        y  = {sd.mx, 4'd0};
        vq = ({1'b0, y} + 13'd1 + {9'd0, y[11:8]}) >> 8;
        p1_val_next = {1'b0, y} + vq;
    end

    // Stage 2: wrap hue into one turn, adjust S and V.
    always_comb
    begin
        logic signed [17:0] sum;
        logic [16:0] t;
        sum = $signed({3'b000, p1_hue_reg}) + 18'(hue_shift_reg) + 18'sd46080;
        t   = sum[16:0];
        if (t >= 17'd92160)
            t = t - 17'd92160;
        else if (t >= 17'd69120)
            t = t - 17'd69120;
        else if (t >= 17'd46080)
            t = t - 17'd46080;
        else if (t >= 17'd23040)
            t = t - 17'd23040;
        p2_h_next = t[14:0];
        p2_s_next = adjust(p1_sat_reg, sat_adjust_reg, sat_additive_reg);
        p2_v_next = adjust(p1_val_reg, val_adjust_reg, val_additive_reg);
    end

    // Stage 3: split hue into sector and offset within it.
    always_comb
    begin
        logic [14:0] fw;
        if (p2_h_reg >= 15'd19200)
        begin
            p3_sector_next = 3'd5;
            fw = p2_h_reg - 15'd19200;
        end
        else if (p2_h_reg >= 15'd15360)
        begin
            p3_sector_next = 3'd4;
            fw = p2_h_reg - 15'd15360;
        end
        else if (p2_h_reg >= 15'd11520)
        begin
            p3_sector_next = 3'd3;
            fw = p2_h_reg - 15'd11520;
        end
        else if (p2_h_reg >= 15'd7680)
        begin
            p3_sector_next = 3'd2;
            fw = p2_h_reg - 15'd7680;
        end
        else if (p2_h_reg >= 15'd3840)
        begin
            p3_sector_next = 3'd1;
            fw = p2_h_reg - 15'd3840;
        end
        else
        begin
            p3_sector_next = 3'd0;
            fw = p2_h_reg;
        end
        p3_f_next = fw[11:0];
    end

    // Stage 6: s*f/3840 = floor(floor(p/256)/15), by reciprocal.
    assign p6_sf = p5_sfm_reg[31:19];
    assign p6_kq = 13'd4096 - p6_sf;
    assign p6_kt = p5_kp_reg + p6_sf;

    // Stage 7: scale to 8 bits, route by sector, or pass through.
    always_comb
    begin
        logic [20:0] vw;
        logic [7:0]  cv, cp, cq, ct;
        vw = {p6_v_reg, 8'd0} - {8'd0, p6_v_reg};
        cv = vw[19:12];
        cp = chan_of(p6_xp_reg);
        cq = chan_of(p6_xq_reg);
        ct = chan_of(p6_xt_reg);
        case (p6_sector_reg)
            3'd0:    p7_out_next = '{red_out: cv, green_out: ct, blue_out: cp};
            3'd1:    p7_out_next = '{red_out: cq, green_out: cv, blue_out: cp};
            3'd2:    p7_out_next = '{red_out: cp, green_out: cv, blue_out: ct};
            3'd3:    p7_out_next = '{red_out: cp, green_out: cq, blue_out: cv};
            3'd4:    p7_out_next = '{red_out: ct, green_out: cp, blue_out: cv};
            default: p7_out_next = '{red_out: cv, green_out: cp, blue_out: cq};
        endcase
        if (hue_shift_reg == 16'sd0 && sat_adjust_reg == 15'sd0 && val_adjust_reg == 15'sd0)
            p7_out_next = '{red_out:   p6_pix_reg.red_in,
                            green_out: p6_pix_reg.green_in,
                            blue_out:  p6_pix_reg.blue_in};
    end

    // Valid bits: advance together, hold on output stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_QUO_W; k++)
                dv_valid_reg[k] <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= src_valid;
            for (int k = 0; k < DIV_QUO_W; k++)
                dv_valid_reg[k] <= (k == 0) ? s0_valid_reg : dv_valid_reg[k-1];
            p1_valid_reg <= dv_valid_reg[DIV_QUO_W-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_pix_reg <= src_data;
            for (int k = 0; k < DIV_QUO_W; k++)
                dv_side_reg[k] <= (k == 0) ? side_next : dv_side_reg[k-1];

            p1_pix_reg <= dv_side_reg[DIV_QUO_W-1].pix;
            p1_hue_reg <= p1_hue_next;
            p1_sat_reg <= p1_sat_next;
            p1_val_reg <= p1_val_next;

            p2_pix_reg <= p1_pix_reg;
            p2_h_reg   <= p2_h_next;
            p2_s_reg   <= p2_s_next;
            p2_v_reg   <= p2_v_next;

            p3_pix_reg    <= p2_pix_reg;
            p3_sector_reg <= p3_sector_next;
            p3_f_reg      <= p3_f_next;
            p3_s_reg      <= p2_s_reg;
            p3_v_reg      <= p2_v_reg;

            p4_pix_reg    <= p3_pix_reg;
            p4_sector_reg <= p3_sector_reg;
            p4_v_reg      <= p3_v_reg;
            p4_p_reg      <= {12'd0, p3_s_reg} * {13'd0, p3_f_reg};
            p4_kp_reg     <= 13'd4096 - p3_s_reg;

            p5_pix_reg    <= p4_pix_reg;
            p5_sector_reg <= p4_sector_reg;
            p5_v_reg      <= p4_v_reg;
            p5_kp_reg     <= p4_kp_reg;
            p5_sfm_reg    <= {17'd0, p4_p_reg[24:8]} * 34'd34953;

            p6_pix_reg    <= p5_pix_reg;
            p6_sector_reg <= p5_sector_reg;
            p6_v_reg      <= p5_v_reg;
            p6_xp_reg     <= 25'(p5_v_reg * p5_kp_reg);
            p6_xq_reg     <= 25'(p5_v_reg * p6_kq);
            p6_xt_reg     <= 25'(p5_v_reg * p6_kt);

            p7_out_reg <= p7_out_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (p7_valid_reg && dst_stall) |=> $stable(p6_valid_reg) && $stable(p1_valid_reg))
        else $error("pipeline moved while output stalled");
    a_sv_range: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> (p3_s_reg <= 13'd4096) && (p3_v_reg <= 13'd4096))
        else $error("S or V out of range after clamp");
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> (p3_sector_reg <= 3'd5) && (p3_f_reg < 12'd3840))
        else $error("hue sector split out of range");
    a_sf_range: assert property (@(posedge clk) disable iff (!rst_n)
        p6_valid_reg |-> (p6_xt_reg <= 25'd16777216) && (p6_xq_reg <= 25'd16777216))
        else $error("channel product out of range");
`endif

endmodule
